FILE: hw/rtl/uitf_pkg.sv
// ----------------------------------------------------------------------------
// uitf_pkg
// shared types and constants of the uart receive framer with idle timeout
// ----------------------------------------------------------------------------
package uitf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_LENGTH     = 2'd0;
  localparam logic [1:0] REG_IDLE_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_WAKE_MASK      = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_ENABLE = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // reset values
  localparam logic [8:0]  RST_MAX_LENGTH     = 9'd256;
  localparam logic [15:0] RST_IDLE_TIMEOUT   = 16'd10;
  localparam logic [4:0]  RST_WAKE_MASK      = 5'd0;
  localparam logic        RST_TIMEOUT_ENABLE = 1'b0;

  // input command codes
  localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_LINE_ERR = 2'd2;
  localparam logic [1:0] CMD_TX_DONE  = 2'd3;

  // wake mask bits
  localparam int unsigned WM_BYTE    = 0;
  localparam int unsigned WM_FULL    = 1;
  localparam int unsigned WM_TIMEOUT = 2;
  localparam int unsigned WM_ERROR   = 3;
  localparam int unsigned WM_TX_DONE = 4;

  // wake reason codes
  localparam logic [3:0] WR_RX      = 4'b0001;
  localparam logic [3:0] WR_TIMEOUT = 4'b0011;
  localparam logic [3:0] WR_ERROR   = 4'b0100;
  localparam logic [3:0] WR_TX_DONE = 4'b1000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic        store_enable;
    logic [7:0]  store_address;
    logic [7:0]  store_byte;
    logic        wake;
    logic [3:0]  wake_reason;
    logic [8:0]  frame_length;
    logic [15:0] error_total;
  } out_beat_t;

  typedef struct packed {
    logic [8:0]  max_length;
    logic [15:0] idle_timeout;
    logic [4:0]  wake_mask;
    logic        timeout_enable;
  } cfg_t;

  // classified event kind, one-hot
  typedef enum logic [3:0] {
    EV_RX      = 4'b0001,
    EV_TICK    = 4'b0010,
    EV_ERROR   = 4'b0100,
    EV_TX_DONE = 4'b1000
  } event_t;

  typedef struct packed {
    event_t     kind;
    logic [7:0] rx_byte;
  } op_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: hw/rtl/uitf_front.sv
// ----------------------------------------------------------------------------
// uitf_front
// accepts input beats and classifies them into event items for the queue
// ----------------------------------------------------------------------------
module uitf_front import uitf_pkg::*; (
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output op_item_t  push_item
);

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_item.rx_byte = in_data.rx_byte;
    case (in_data.command)
      CMD_RX_BYTE:  push_item.kind = EV_RX;
      CMD_TICK:     push_item.kind = EV_TICK;
      CMD_LINE_ERR: push_item.kind = EV_ERROR;
      CMD_TX_DONE:  push_item.kind = EV_TX_DONE;
      default:      push_item.kind = EV_TX_DONE;
    endcase
  end

endmodule

FILE: hw/rtl/uitf_queue.sv
// ----------------------------------------------------------------------------
// uitf_queue
// short event queue between the front and back parts
// ----------------------------------------------------------------------------
module uitf_queue import uitf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_item_t  push_item,
  input  logic      pop,
  output op_item_t  head,
  output q_status_t q_status
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  op_item_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/uitf_back.sv
// ----------------------------------------------------------------------------
// uitf_back
// executes queued events against the framer state and registers the result
// ----------------------------------------------------------------------------
module uitf_back import uitf_pkg::*; #(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  op_item_t  head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // frame store depth, capped at the largest limit a 9-bit index can hold
  localparam logic [8:0] DEPTH_LIM = (BUF_DEPTH > 511) ? 9'd511 : 9'(BUF_DEPTH);

  logic [8:0]  write_index;
  logic [8:0]  committed_length;
  logic [15:0] idle_countdown;
  logic [15:0] error_count;

  logic [8:0]  write_index_next;
  logic [8:0]  committed_length_next;
  logic [15:0] idle_countdown_next;
  logic [15:0] error_count_next;
  out_beat_t   out_data_next;

  logic [8:0]  limit;
  logic [8:0]  index_inc;
  logic [15:0] countdown_dec;
  logic [3:0]  reason;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  // frame limit clamped to 1..depth
  always_comb begin
    if (cfg.max_length == '0) begin
      limit = 9'd1;
    end else if (cfg.max_length > DEPTH_LIM) begin
      limit = DEPTH_LIM;
    end else begin
      limit = cfg.max_length;
    end
  end

  assign index_inc     = write_index + 9'd1;
  assign countdown_dec = (idle_countdown != '0) ? idle_countdown - 16'd1 : idle_countdown;

  always_comb begin
    write_index_next      = write_index;
    committed_length_next = committed_length;
    idle_countdown_next   = idle_countdown;
    error_count_next      = error_count;
    reason                = '0;
    out_data_next         = '0;

    case (head.kind)
      EV_RX: begin
        out_data_next.store_enable  = 1'b1;
        out_data_next.store_address = write_index[7:0];
        out_data_next.store_byte    = head.rx_byte;
        idle_countdown_next         = cfg.idle_timeout;
        write_index_next            = index_inc;
        if (index_inc >= limit) begin
          committed_length_next = index_inc;
          write_index_next      = '0;
          if (cfg.wake_mask[WM_FULL]) begin
            reason = reason | WR_RX;
          end
        end
        if (cfg.wake_mask[WM_BYTE]) begin
          reason = reason | WR_RX;
        end
      end
      EV_TICK: begin
        if (cfg.timeout_enable && write_index != '0 && committed_length != limit) begin
          idle_countdown_next = countdown_dec;
          if (countdown_dec == '0) begin
            committed_length_next = write_index;
            write_index_next      = '0;
            idle_countdown_next   = cfg.idle_timeout;
            if (cfg.wake_mask[WM_TIMEOUT]) begin
              reason = reason | WR_TIMEOUT;
            end
          end
        end
      end
      EV_ERROR: begin
        error_count_next    = error_count + 16'd1;
        idle_countdown_next = cfg.idle_timeout;
        if (cfg.wake_mask[WM_ERROR]) begin
          reason = reason | WR_ERROR;
        end
      end
      EV_TX_DONE: begin
        if (cfg.wake_mask[WM_TX_DONE]) begin
          reason = reason | WR_TX_DONE;
        end
      end
      default: begin
      end
    endcase

    out_data_next.wake         = (reason != '0);
    out_data_next.wake_reason  = reason;
    out_data_next.frame_length = committed_length_next;
    out_data_next.error_total  = error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index      <= '0;
      committed_length <= '0;
      idle_countdown   <= RST_IDLE_TIMEOUT;
      error_count      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        write_index      <= write_index_next;
        committed_length <= committed_length_next;
        idle_countdown   <= idle_countdown_next;
        error_count      <= error_count_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= out_data_next;
    end
  end

endmodule

FILE: hw/rtl/uart_rx_idle_timeout_framer.sv
// ----------------------------------------------------------------------------
// uart_rx_idle_timeout_framer
// uart receive framer with idle timeout, error count and wake reporting
// ----------------------------------------------------------------------------
// Every accepted input beat yields exactly one output beat. A beat is one
// event: a received byte, a timer tick, a line error or a transmit
// completion. The block sustains one beat per clock while the output side is
// not stalled; a taken input passes through the event queue and then the
// output register. The two-entry event queue lets the input side keep going
// while a result waits, and the per-event state update in the back part
// sets that rate. Received bytes come out with their frame store address;
// when the index reaches the frame limit (max_length clamped to 1..BUF_DEPTH,
// at most 511) the frame length is latched and the index restarts. With
// timeout_enable set, ticks run an idle countdown that commits a partial
// frame at zero; a latched length equal to the limit blocks later timeouts
// while the two stay equal. Configuration is written through a plain write
// port and is expected only while no beat is in flight.
// ----------------------------------------------------------------------------
module uart_rx_idle_timeout_framer import uitf_pkg::*; #(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  // input beats
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  // output beats
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  // configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      push;
  op_item_t  push_item;
  logic      pop;
  op_item_t  head;
  q_status_t q_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length     <= RST_MAX_LENGTH;
      cfg.idle_timeout   <= RST_IDLE_TIMEOUT;
      cfg.wake_mask      <= RST_WAKE_MASK;
      cfg.timeout_enable <= RST_TIMEOUT_ENABLE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_LENGTH:     cfg.max_length     <= cfg_data[8:0];
        REG_IDLE_TIMEOUT:   cfg.idle_timeout   <= cfg_data;
        REG_WAKE_MASK:      cfg.wake_mask      <= cfg_data[4:0];
        REG_TIMEOUT_ENABLE: cfg.timeout_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: take beats and classify the event
  uitf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // short queue decoupling front from back
  uitf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // back: state update and registered result
  uitf_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/uart_rx_idle_timeout_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_rx_idle_timeout_framer_tb
// self-checking bench for the uart receive framer with idle timeout
// ----------------------------------------------------------------------------
// A stimulus table walks the register extremes, every command and the corner
// cases of the framer (zero and oversized frame limit, zero timeout, full
// frame blocking later timeouts, countdown untouched by a timeout write).
// Random phases with fresh register settings follow, then a long byte-heavy
// run and a short burst of back-to-back line errors. Every accepted input
// beat is run through a behavioral copy of the framer and the expected
// output beat is queued; output beats are compared field by field in order.
// Both sides idle and stall at random, with some phases running flat out.
// ----------------------------------------------------------------------------
module uart_rx_idle_timeout_framer_tb;
  import uitf_pkg::*;

  localparam int unsigned FRAME_STORE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT       = 1000000;
  localparam int unsigned ERR_BURST_BEATS   = 20;
  localparam int unsigned MAX_REPORTS       = 10;

  // one line of the directed stimulus table: a register write or an input beat
  typedef struct packed {
    bit                    is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    in_beat_t              beat;
    bit                    typed;
    out_beat_t             want;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // framer copy: register shadows and running state, reset values
  logic [8:0]  max_len_reg     = RST_MAX_LENGTH;
  logic [15:0] idle_reload_reg = RST_IDLE_TIMEOUT;
  logic [4:0]  wake_en_reg     = RST_WAKE_MASK;
  logic        timeout_on_reg  = RST_TIMEOUT_ENABLE;
  logic [8:0]  fill_index      = '0;
  logic [8:0]  last_frame_len  = '0;
  logic [15:0] quiet_ticks     = RST_IDLE_TIMEOUT;
  logic [15:0] line_errors     = '0;

  out_beat_t   pending_results[$];
  stim_row_t   plan[$];
  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;
  bit          sender_steady   = 1'b0;
  bit          receiver_steady = 1'b0;

  uart_rx_idle_timeout_framer #(
    .BUF_DEPTH(FRAME_STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // run one event through the framer copy and return the output beat it owes
  function automatic out_beat_t advance_framer(in_beat_t b);
    out_beat_t  r;
    logic [8:0] lim;
    logic [3:0] reason;
    r = '0;
    reason = '0;
    // frame limit is max_length clamped into 1..store depth
    if (max_len_reg == 9'd0) begin
      lim = 9'd1;
    end else if (max_len_reg > FRAME_STORE_DEPTH) begin
      lim = 9'(FRAME_STORE_DEPTH);
    end else begin
      lim = max_len_reg;
    end
    case (b.command)
      CMD_RX_BYTE: begin
        r.store_enable  = 1'b1;
        r.store_address = fill_index[7:0];
        r.store_byte    = b.rx_byte;
        quiet_ticks     = idle_reload_reg;
        fill_index      = fill_index + 9'd1;
        if (fill_index >= lim) begin
          // full frame: latch its length and restart the index
          last_frame_len = fill_index;
          fill_index     = '0;
          if (wake_en_reg[WM_FULL]) reason |= WR_RX;
        end
        if (wake_en_reg[WM_BYTE]) reason |= WR_RX;
      end
      CMD_TICK: begin
        // a latched full-length frame blocks the countdown
        if (timeout_on_reg && fill_index != 9'd0 && last_frame_len != lim) begin
          if (quiet_ticks != 16'd0) quiet_ticks = quiet_ticks - 16'd1;
          if (quiet_ticks == 16'd0) begin
            last_frame_len = fill_index;
            fill_index     = '0;
            quiet_ticks    = idle_reload_reg;
            if (wake_en_reg[WM_TIMEOUT]) reason |= WR_TIMEOUT;
          end
        end
      end
      CMD_LINE_ERR: begin
        line_errors = line_errors + 16'd1;
        if (wake_en_reg[WM_ERROR]) reason |= WR_ERROR;
        quiet_ticks = idle_reload_reg;
      end
      default: begin
        if (wake_en_reg[WM_TX_DONE]) reason |= WR_TX_DONE;
      end
    endcase
    r.wake         = (reason != 4'd0);
    r.wake_reason  = reason;
    r.frame_length = last_frame_len;
    r.error_total  = line_errors;
    return r;
  endfunction

  function automatic out_beat_t typed_result(logic en, logic [7:0] addr, logic [7:0] data,
                                             logic [3:0] reason, logic [8:0] flen,
                                             logic [15:0] errs);
    out_beat_t r;
    r.store_enable  = en;
    r.store_address = addr;
    r.store_byte    = data;
    r.wake          = (reason != 4'd0);
    r.wake_reason   = reason;
    r.frame_length  = flen;
    r.error_total   = errs;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_value = v;
    return row;
  endfunction

  function automatic stim_row_t beat_row(logic [1:0] cmd, logic [7:0] data);
    stim_row_t row;
    row = '0;
    row.beat.command = cmd;
    row.beat.rx_byte = data;
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [1:0] cmd, logic [7:0] data, out_beat_t w);
    stim_row_t row;
    row       = beat_row(cmd, data);
    row.typed = 1'b1;
    row.want  = w;
    return row;
  endfunction

  // random event mix: mostly bytes and ticks so frames fill and time out,
  // the rest line errors and transmit completions as noise
  function automatic in_beat_t random_beat(int unsigned rx_pct);
    in_beat_t    b;
    int unsigned r;
    int unsigned tick_cut;
    r        = $urandom_range(0, 99);
    tick_cut = rx_pct + (100 - rx_pct) * 3 / 4;
    b.rx_byte = 8'($urandom_range(0, 255));
    if (r < rx_pct) begin
      b.command = CMD_RX_BYTE;
    end else if (r < tick_cut) begin
      b.command = CMD_TICK;
    end else if (r < tick_cut + (100 - tick_cut) / 2) begin
      b.command = CMD_LINE_ERR;
    end else begin
      b.command = CMD_TX_DONE;
    end
    return b;
  endfunction

  function automatic string beat_text(out_beat_t b);
    return $sformatf("en=%0d addr=%02h byte=%02h wake=%0d reason=%h len=%0d errs=%0d",
                     b.store_enable, b.store_address, b.store_byte, b.wake,
                     b.wake_reason, b.frame_length, b.error_total);
  endfunction

  // drop valid and let every owed beat come back before touching registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MAX_LENGTH:   max_len_reg     = v[8:0];
      REG_IDLE_TIMEOUT: idle_reload_reg = v;
      REG_WAKE_MASK:    wake_en_reg     = v[4:0];
      default:          timeout_on_reg  = v[0];
    endcase
  endtask

  // offer one input beat after a random gap; valid stays up into the next
  // beat when that one draws no gap
  task automatic send_item(in_beat_t b, bit typed, out_beat_t want);
    int unsigned gap;
    out_beat_t   predicted;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    predicted = advance_framer(b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_phase(int unsigned items, int unsigned rx_pct);
    for (int unsigned i = 0; i < items; i++) begin
      send_item(random_beat(rx_pct), 1'b0, '0);
    end
  endtask

  // fresh settings per phase; unused upper bits of the data carry junk
  task automatic random_settings();
    int unsigned r;
    logic [8:0]  ml;
    logic [15:0] idle;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      ml = 9'($urandom_range(0, 8));
    end else if (r == 6) begin
      ml = 9'd256;
    end else if (r == 7) begin
      ml = 9'($urandom_range(257, 511));
    end else begin
      ml = 9'($urandom_range(1, 256));
    end
    idle = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6)) : 16'($urandom);
    write_reg(REG_MAX_LENGTH, {7'($urandom), ml});
    write_reg(REG_IDLE_TIMEOUT, idle);
    write_reg(REG_WAKE_MASK, {11'($urandom), 5'($urandom_range(0, 31))});
    write_reg(REG_TIMEOUT_ENABLE, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
  endtask

  // output side: stall a random number of cycles ahead of each beat
  initial begin : output_stalls
    int unsigned gap;
    forever begin
      gap = receiver_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted output beat with the oldest owed result
  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected output beat: %s", beat_text(out_data));
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.store_enable  !== want.store_enable  ||
            out_data.store_address !== want.store_address ||
            out_data.store_byte    !== want.store_byte    ||
            out_data.wake          !== want.wake          ||
            out_data.wake_reason   !== want.wake_reason   ||
            out_data.frame_length  !== want.frame_length  ||
            out_data.error_total   !== want.error_total) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("output beat mismatch at cycle %0d", cycles);
            $display("  expected %s", beat_text(want));
            $display("  actual   %s", beat_text(out_data));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    // reset defaults: limit 256, timeout 10, no wakes, countdown off
    plan.push_back(checked_row(CMD_RX_BYTE, 8'h00,
      typed_result(1'b1, 8'd0, 8'h00, 4'd0, 9'd0, 16'd0)));
    plan.push_back(checked_row(CMD_RX_BYTE, 8'hff,
      typed_result(1'b1, 8'd1, 8'hff, 4'd0, 9'd0, 16'd0)));
    plan.push_back(checked_row(CMD_TICK, 8'hff,
      typed_result(1'b0, 8'd0, 8'h00, 4'd0, 9'd0, 16'd0)));
    plan.push_back(checked_row(CMD_LINE_ERR, 8'h00,
      typed_result(1'b0, 8'd0, 8'h00, 4'd0, 9'd0, 16'd1)));
    plan.push_back(checked_row(CMD_TX_DONE, 8'hff,
      typed_result(1'b0, 8'd0, 8'h00, 4'd0, 9'd0, 16'd1)));
    // all wakes on, zero timeout, zero max_length means frames of one
    plan.push_back(reg_row(REG_WAKE_MASK, 16'h001f));
    plan.push_back(reg_row(REG_TIMEOUT_ENABLE, 16'h0001));
    plan.push_back(reg_row(REG_IDLE_TIMEOUT, 16'h0000));
    plan.push_back(reg_row(REG_MAX_LENGTH, 16'h0000));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'haa));
    plan.push_back(checked_row(CMD_RX_BYTE, 8'h5a,
      typed_result(1'b1, 8'd0, 8'h5a, WR_RX, 9'd1, 16'd1)));
    plan.push_back(checked_row(CMD_TX_DONE, 8'h00,
      typed_result(1'b0, 8'd0, 8'h00, WR_TX_DONE, 9'd1, 16'd1)));
    plan.push_back(checked_row(CMD_LINE_ERR, 8'hff,
      typed_result(1'b0, 8'd0, 8'h00, WR_ERROR, 9'd1, 16'd2)));
    // zero timeout: the first enabled tick commits the partial frame
    plan.push_back(reg_row(REG_MAX_LENGTH, 16'h0003));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'h12));
    plan.push_back(checked_row(CMD_TICK, 8'h00,
      typed_result(1'b0, 8'd0, 8'h00, WR_TIMEOUT, 9'd1, 16'd2)));
    // full frame of three, then a partial one whose timeout is blocked
    plan.push_back(reg_row(REG_IDLE_TIMEOUT, 16'h0002));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'h01));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'h80));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'h7f));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'h33));
    plan.push_back(beat_row(CMD_TICK, 8'h00));
    plan.push_back(beat_row(CMD_TICK, 8'h00));
    // oversized max_length acts as the store depth and unblocks the timeout
    plan.push_back(reg_row(REG_MAX_LENGTH, 16'hffff));
    plan.push_back(beat_row(CMD_TICK, 8'h00));
    plan.push_back(beat_row(CMD_TICK, 8'h00));
    // timeout write leaves the running countdown alone; errors reload it
    plan.push_back(reg_row(REG_IDLE_TIMEOUT, 16'hffff));
    plan.push_back(beat_row(CMD_RX_BYTE, 8'hc3));
    plan.push_back(reg_row(REG_IDLE_TIMEOUT, 16'h0001));
    plan.push_back(beat_row(CMD_TICK, 8'h00));
    plan.push_back(beat_row(CMD_LINE_ERR, 8'h00));
    plan.push_back(beat_row(CMD_TICK, 8'h00));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_item(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // random phases; every fourth runs flat out, some idle only the input
    for (int unsigned p = 0; p < 9; p++) begin
      if (p == 0) begin
        write_reg(REG_MAX_LENGTH, 16'd1);
        write_reg(REG_IDLE_TIMEOUT, 16'd0);
        write_reg(REG_WAKE_MASK, 16'd31);
        write_reg(REG_TIMEOUT_ENABLE, 16'd1);
      end else if (p == 1) begin
        write_reg(REG_MAX_LENGTH, 16'd256);
        write_reg(REG_IDLE_TIMEOUT, 16'd65535);
        write_reg(REG_WAKE_MASK, 16'd0);
        write_reg(REG_TIMEOUT_ENABLE, 16'd0);
      end else begin
        random_settings();
      end
      sender_steady   = (p % 4 == 3);
      receiver_steady = (p % 4 >= 2);
      run_phase(95, 55);
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;

    // long byte-heavy run at full store depth so addresses reach the top
    write_reg(REG_MAX_LENGTH, 16'd256);
    write_reg(REG_IDLE_TIMEOUT, 16'd3);
    write_reg(REG_WAKE_MASK, 16'd3);
    write_reg(REG_TIMEOUT_ENABLE, 16'd1);
    run_phase(300, 90);

    // back-to-back line errors
    write_reg(REG_WAKE_MASK, 16'd8);
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    for (int unsigned i = 0; i < ERR_BURST_BEATS; i++) begin
      send_item({CMD_LINE_ERR, 8'($urandom_range(0, 255))}, 1'b0, '0);
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/uitf_pkg.sv
hw/rtl/uitf_front.sv
hw/rtl/uitf_queue.sv
hw/rtl/uitf_back.sv
hw/rtl/uart_rx_idle_timeout_framer.sv
tb/uart_rx_idle_timeout_framer_tb.sv
